/* design/atfad_pkg.sv */
// ----------------------------------------------------------------------------
// Fault address decoder package
// Shared types and instruction-match constants for the load/store effective
// address decoder and its top level.
// ----------------------------------------------------------------------------
package atfad_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned REG_IDX_W = 4;

  // Register file as one packed word per entry.
  typedef logic [NUM_REGS-1:0][DATA_W-1:0] regfile_t;

  // What the decoder hands back for one instruction word.
  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic              recognized;
  } dec_result_t;

  // Shift type codes, taken from bits 6:5 of the instruction.
  typedef enum logic [1:0] {
    SH_LSL = 2'b00,
    SH_LSR = 2'b01,
    SH_ASR = 2'b10,
    SH_ROR = 2'b11
  } shift_type_t;

  // Shift control byte that means "no shift at all".
  localparam logic [7:0] SHIFT_CTL_PASS = 8'h0B;

  // Thumb encodings (lower halfword only).
  localparam logic [15:0] T_MASK_F800 = 16'hF800;
  localparam logic [15:0] T_MASK_F200 = 16'hF200;
  localparam logic [15:0] T_MASK_F700 = 16'hF700;
  localparam logic [15:0] T_MASK_F000 = 16'hF000;
  localparam logic [15:0] T_MASK_E000 = 16'hE000;
  localparam logic [15:0] T_PC_REL    = 16'h4800;
  localparam logic [15:0] T_REG_REG   = 16'h5000;
  localparam logic [15:0] T_REG_REG_S = 16'h5200;
  localparam logic [15:0] T_REG_IMM   = 16'h6000;
  localparam logic [15:0] T_HALF_IMM  = 16'h8000;
  localparam logic [15:0] T_SP_REL    = 16'h9000;
  localparam logic [15:0] T_PUSH_POP  = 16'hB500;
  localparam logic [15:0] T_LDM_STM   = 16'hC000;

  localparam logic [REG_IDX_W-1:0] T_PC_REG = 4'd15;
  localparam logic [REG_IDX_W-1:0] T_SP_REG = 4'd13;

  // ARM encodings.
  localparam logic [31:0] A_SWP_MASK = 32'h0FB00FF0;
  localparam logic [31:0] A_SWP      = 32'h01000090;
  localparam logic [31:0] A_SDT_MASK = 32'h0C000000;
  localparam logic [31:0] A_SDT      = 32'h04000000;
  localparam logic [31:0] A_HW_MASK  = 32'h0E400F90;
  localparam logic [31:0] A_HW_REG   = 32'h00000090;
  localparam logic [31:0] A_HW_IMM   = 32'h00400090;
  localparam logic [31:0] A_BDT_MASK = 32'h0E000000;
  localparam logic [31:0] A_BDT      = 32'h08000000;

endpackage

/* design/arm_thumb_fault_address_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ARM/Thumb fault address decoder
// Sixteen-entry register file plus a load/store effective-address decoder.
// ----------------------------------------------------------------------------
// Usage
//   Input transactions arrive on in_valid/in_ready. With mode low a
//   transaction writes reg_value into register reg_index and yields no
//   output. With mode high it decodes instr_word (ARM, or Thumb on the low
//   halfword when thumb is set) and yields exactly one output transaction on
//   out_valid/out_ready carrying access_address and recognized. Unmatched
//   words return address zero with recognized low.
//   A decode passes through two registers: the input register, where the
//   register file is read, shifted and added, then the result register.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; a new transaction is taken while a result waits, as long as
//   the input register can move on in the same cycle.
//   When the receiver stalls, the result register holds; a decode waiting
//   behind it stays in the input register and in_ready drops. Register
//   writes in the input register never wait for the output side.
//   Reset clears both valid flags and sets all sixteen registers to zero.
// ----------------------------------------------------------------------------
module arm_thumb_fault_address_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [atfad_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [atfad_pkg::DATA_W-1:0]    reg_value,
  input  logic [atfad_pkg::DATA_W-1:0]    instr_word,
  input  logic                            thumb,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [atfad_pkg::DATA_W-1:0]    access_address,
  output logic                            recognized
);

  // Input register stage.
  logic                            s1_valid;
  logic                            s1_mode;
  logic [atfad_pkg::REG_IDX_W-1:0] s1_index;
  logic [atfad_pkg::DATA_W-1:0]    s1_value;
  logic [atfad_pkg::DATA_W-1:0]    s1_word;
  logic                            s1_thumb;

  // The register file lives in flip-flops so that the three read ports the
  // decoder needs are available in the same cycle.
  atfad_pkg::regfile_t             regs;
  atfad_pkg::dec_result_t          dec;

  logic                            out_can_load;
  logic                            s1_advance;

  // The result register can take a new value when it is empty or being
  // drained this cycle. A register write leaves the input stage regardless.
  assign out_can_load = !out_valid || out_ready;
  assign s1_advance   = s1_valid && (!s1_mode || out_can_load);
  assign in_ready     = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= mode;
      s1_index <= reg_index;
      s1_value <= reg_value;
      s1_word  <= instr_word;
      s1_thumb <= thumb;
    end
  end

  // Writes commit as the transaction leaves the input stage, so any decode
  // behind it in the stream sees the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (s1_valid && !s1_mode) begin
      regs[s1_index] <= s1_value;
    end
  end

  atfad_decode u_decode (
    .instr_word (s1_word),
    .thumb      (s1_thumb),
    .regs       (regs),
    .result     (dec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_can_load) begin
      out_valid <= s1_valid && s1_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (out_can_load && s1_valid && s1_mode) begin
      access_address <= dec.addr;
      recognized     <= dec.recognized;
    end
  end

  // A reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // A fresh result only ever follows a decode leaving the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_mode))
    else $error("result appeared without a decode transaction");

  // Unrecognised words must report address zero.
  a_unrecognised_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !recognized |-> access_address == '0)
    else $error("unrecognised word with non-zero address");

  // A register write leaving the input stage is visible in the register file in the following cycle.
  a_write_commit: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_mode |=> regs[$past(s1_index)] == $past(s1_value))
    else $error("register write lost");

endmodule

/* design/atfad_decode.sv */
// ----------------------------------------------------------------------------
// Fault address decoder: instruction decode and address arithmetic
// Matches one ARM or Thumb load/store word, runs the offset shifter and
// forms the effective address with a single add or subtract.
// ----------------------------------------------------------------------------
module atfad_decode (
  input  logic [atfad_pkg::DATA_W-1:0] instr_word,
  input  logic                         thumb,
  input  atfad_pkg::regfile_t          regs,
  output atfad_pkg::dec_result_t       result
);

  logic [15:0]                   tw;
  logic [atfad_pkg::DATA_W-1:0]  tsext;
  logic [atfad_pkg::DATA_W-1:0]  rn_val;
  logic [atfad_pkg::DATA_W-1:0]  rm_val;
  logic [7:0]                    sh_ctl;
  logic [atfad_pkg::DATA_W-1:0]  sh_amt;
  logic [4:0]                    sh_amt5;
  logic                          sh_big;
  logic                          sh_fill;
  logic [2*atfad_pkg::DATA_W-1:0] sh_rot;
  logic [atfad_pkg::DATA_W-1:0]  shifted;
  logic [atfad_pkg::DATA_W-1:0]  base;
  logic [atfad_pkg::DATA_W-1:0]  offset;
  logic                          sub;
  logic                          rec;

  assign tw     = instr_word[15:0];
  assign tsext  = {{24{tw[7]}}, tw[7:0]};
  assign rn_val = regs[instr_word[19:16]];
  assign rm_val = regs[instr_word[3:0]];

  // Offset shifter. The amount comes from a register or from an immediate.
  assign sh_ctl  = instr_word[11:4];
  assign sh_amt  = sh_ctl[0] ? regs[sh_ctl[7:4]]
                             : {{(atfad_pkg::DATA_W-5){1'b0}}, sh_ctl[7:3]};
  assign sh_amt5 = sh_amt[4:0];
  assign sh_big  = |sh_amt[atfad_pkg::DATA_W-1:5];
  assign sh_fill = rm_val[atfad_pkg::DATA_W-1];
  assign sh_rot  = {rm_val, rm_val} >> sh_amt5;

  always_comb begin
    shifted = rm_val;
    if (sh_ctl != atfad_pkg::SHIFT_CTL_PASS) begin
      case (atfad_pkg::shift_type_t'(sh_ctl[2:1]))
        atfad_pkg::SH_LSL: shifted = sh_big ? '0 : (rm_val << sh_amt5);
        atfad_pkg::SH_LSR: shifted = sh_big ? '0 : (rm_val >> sh_amt5);
        atfad_pkg::SH_ASR: shifted = sh_big ? {atfad_pkg::DATA_W{sh_fill}}
                                            : $unsigned($signed(rm_val) >>> sh_amt5);
        default:           shifted = sh_rot[atfad_pkg::DATA_W-1:0];
      endcase
    end
  end

  // Form selection: every recognised form reduces to base plus or minus offset.
  always_comb begin
    base   = '0;
    offset = '0;
    sub    = 1'b0;
    rec    = 1'b1;
    if (thumb) begin
      if ((tw & atfad_pkg::T_MASK_F800) == atfad_pkg::T_PC_REL) begin
        base   = regs[atfad_pkg::T_PC_REG];
        offset = tsext;
      end else if ((tw & atfad_pkg::T_MASK_F200) == atfad_pkg::T_REG_REG) begin
        base   = regs[{1'b0, tw[5:3]}];
        offset = regs[{1'b0, tw[8:6]}];
      end else if ((tw & atfad_pkg::T_MASK_F200) == atfad_pkg::T_REG_REG_S) begin
        base   = regs[{1'b0, tw[5:3]}];
        offset = regs[{2'b00, tw[7:6]}];
      end else if (((tw & atfad_pkg::T_MASK_E000) == atfad_pkg::T_REG_IMM) ||
                   ((tw & atfad_pkg::T_MASK_F000) == atfad_pkg::T_HALF_IMM)) begin
        base   = regs[{1'b0, tw[5:3]}];
        offset = {{(atfad_pkg::DATA_W-7){1'b0}}, tw[10:6], 2'b00};
      end else if ((tw & atfad_pkg::T_MASK_F000) == atfad_pkg::T_SP_REL) begin
        base   = regs[atfad_pkg::T_SP_REG];
        offset = tsext;
      end else if ((tw & atfad_pkg::T_MASK_F700) == atfad_pkg::T_PUSH_POP) begin
        base   = regs[atfad_pkg::T_SP_REG];
      end else if ((tw & atfad_pkg::T_MASK_F000) == atfad_pkg::T_LDM_STM) begin
        base   = regs[{1'b0, tw[10:8]}];
      end else begin
        rec    = 1'b0;
      end
    end else begin
      if ((instr_word & atfad_pkg::A_SWP_MASK) == atfad_pkg::A_SWP) begin
        base = rn_val;
      end else if ((instr_word & atfad_pkg::A_SDT_MASK) == atfad_pkg::A_SDT) begin
        base = rn_val;
        // Post-indexed forms access the unmodified base.
        if (instr_word[24]) begin
          sub    = !instr_word[23];
          offset = instr_word[25] ? shifted
                                  : {{(atfad_pkg::DATA_W-12){1'b0}}, instr_word[11:0]};
        end
      end else if ((instr_word & atfad_pkg::A_HW_MASK) == atfad_pkg::A_HW_REG) begin
        base   = rn_val;
        sub    = !instr_word[23];
        offset = shifted;
      end else if ((instr_word & atfad_pkg::A_HW_MASK) == atfad_pkg::A_HW_IMM) begin
        base   = rn_val;
        sub    = !instr_word[23];
        offset = {{(atfad_pkg::DATA_W-8){1'b0}}, instr_word[11:8], instr_word[3:0]};
      end else if ((instr_word & atfad_pkg::A_BDT_MASK) == atfad_pkg::A_BDT) begin
        base   = rn_val;
      end else begin
        rec    = 1'b0;
      end
    end
  end

  assign result.recognized = rec;
  assign result.addr       = !rec ? '0 : (sub ? (base - offset) : (base + offset));

endmodule
